// ===== src/bhpq_pkg.sv =====
// Shared types and codes for the binary heap priority queue.
// Holds the request and response beat structs, the action and status codes,
// and the key ranking function. Depends on nothing.
package bhpq_pkg;

    // Signed heap key.
    typedef logic signed [31:0] key_t;

    // Request actions.
    typedef enum logic [1:0] {
        ACT_INSERT  = 2'd0,
        ACT_EXTRACT = 2'd1,
        ACT_MODIFY  = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    // Response status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_BAD_POS = 2'd3
    } status_t;

    // Request beat.
    typedef struct packed {
        action_t    action;
        key_t       key_value;
        logic [6:0] position;
    } req_t;

    // Response beat.
    typedef struct packed {
        key_t       result_value;
        status_t    status;
        logic [6:0] entry_count;
    } rsp_t;

    // True when key a belongs strictly above key b; order 0 is max-heap, 1 is min-heap.
    function automatic logic ranks_above(input key_t a, input key_t b, input logic order);
        return order ? (a < b) : (a > b);
    endfunction

endpackage

// ===== src/binary_heap_priority_queue.sv =====
// Binary heap priority queue: top level with the heap memory and its sequencer.
// Depends on bhpq_pkg for the beat structs, codes and key ranking.
//
// The heap lives in one synchronous memory of HEAP_DEPTH 32-bit keys with two
// registered read ports and one write port. Each request walks the tree with a
// single hole: the moving key stays in a register and displaced entries are
// written back one level per step, so every level issues the read, then compares
// and writes back. An insert climbs from the new last entry; an extract moves
// the last entry to the root and descends. A modify climbs from its position
// and then sinks whatever sits at that position. Full, empty and bad-position
// requests leave the heap untouched. One request is worked on at a time; a new
// request is taken while the last response still waits in the output register,
// and a finished request waits in the done state while the receiver stalls.
// The order bit on the configuration port should change only while the heap is
// empty.
module binary_heap_priority_queue #(
    parameter int HEAP_DEPTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    // Configuration write channel.
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_data,
    // Request channel.
    input  logic             s_valid,
    output logic             s_ready,
    input  bhpq_pkg::req_t   s_payload,
    // Response channel.
    output logic             m_valid,
    input  logic             m_ready,
    output bhpq_pkg::rsp_t   m_payload
);

    localparam int IDX_W = $clog2(HEAP_DEPTH);
    localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_EXT_RD  = 7'b0000010,
        S_UP_RD   = 7'b0000100,
        S_UP_CMP  = 7'b0001000,
        S_DN_RD   = 7'b0010000,
        S_DN_CMP  = 7'b0100000,
        S_DONE    = 7'b1000000
    } state_t;

    // Control and datapath registers.
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    hole_reg, hole_next;
    bhpq_pkg::key_t      key_reg, key_next;
    logic                is_insert_reg, is_insert_next;
    logic                right_ok_reg, right_ok_next;
    bhpq_pkg::key_t      res_value_reg, res_value_next;
    bhpq_pkg::status_t   res_status_reg, res_status_next;
    logic                order_reg;
    logic                m_valid_reg, m_valid_next;
    bhpq_pkg::rsp_t      m_payload_reg, m_payload_next;
    // Start position of a modify and the key first pulled down into it.
    logic [IDX_W-1:0]    orig_reg, orig_next;
    bhpq_pkg::key_t      first_reg, first_next;

    // Heap memory and its ports.
    logic [31:0]         heap_mem [HEAP_DEPTH];
    logic [IDX_W-1:0]    rd_a_addr, rd_b_addr, wr_addr;
    logic                wr_en;
    bhpq_pkg::key_t      wr_data;
    bhpq_pkg::key_t      rd_a_reg, rd_b_reg;

    // Tree arithmetic around the hole.
    logic [IDX_W-1:0]    parent_idx;
    logic [CNT_W:0]      left_idx, right_idx, count_ext;
    logic [CMP_W-1:0]    count_wide, pos_wide;
    logic                take_left, take_right;
    bhpq_pkg::key_t      left_best;

    assign parent_idx = IDX_W'((hole_reg - IDX_W'(1)) >> 1);
    assign left_idx   = (CNT_W + 1)'({hole_reg, 1'b1});
    assign right_idx  = left_idx + (CNT_W + 1)'(1);
    assign count_ext  = (CNT_W + 1)'(count_reg);
    assign count_wide = CMP_W'(count_reg);
    assign pos_wide   = CMP_W'(s_payload.position);

    // Pick the child that outranks the moving key; the left child wins ties.
    assign take_left  = bhpq_pkg::ranks_above(rd_a_reg, key_reg, order_reg);
    assign left_best  = take_left ? rd_a_reg : key_reg;
    assign take_right = right_ok_reg && bhpq_pkg::ranks_above(rd_b_reg, left_best, order_reg);

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            order_reg <= cfg_data;
        end
    end

    // Heap memory: one write port, two registered read ports.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            heap_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= heap_mem[rd_a_addr];
        rd_b_reg <= heap_mem[rd_b_addr];
    end

    // Sequencer for insert, extract and modify.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        hole_next       = hole_reg;
        key_next        = key_reg;
        is_insert_next  = is_insert_reg;
        right_ok_next   = right_ok_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        orig_next       = orig_reg;
        first_next      = first_reg;
        rd_a_addr       = parent_idx;
        rd_b_addr       = IDX_W'(right_idx);
        wr_en           = 1'b0;
        wr_addr         = hole_reg;
        wr_data         = key_reg;

        unique case (state_reg)
            S_IDLE: begin
                rd_a_addr = '0;
                rd_b_addr = IDX_W'(count_reg - CNT_W'(1));
                if (s_valid) begin
                    key_next        = s_payload.key_value;
                    res_value_next  = '0;
                    res_status_next = bhpq_pkg::ST_OK;
                    state_next      = S_DONE;
                    unique case (s_payload.action)
                        bhpq_pkg::ACT_INSERT: begin
                            if (count_reg == CNT_W'(HEAP_DEPTH)) begin
                                res_status_next = bhpq_pkg::ST_FULL;
                            end else begin
                                hole_next      = IDX_W'(count_reg);
                                count_next     = count_reg + CNT_W'(1);
                                is_insert_next = 1'b1;
                                state_next     = S_UP_RD;
                            end
                        end
                        bhpq_pkg::ACT_EXTRACT: begin
                            if (count_reg == '0) begin
                                res_status_next = bhpq_pkg::ST_EMPTY;
                            end else begin
                                count_next = count_reg - CNT_W'(1);
                                state_next = S_EXT_RD;
                            end
                        end
                        bhpq_pkg::ACT_MODIFY: begin
                            if (pos_wide == '0 || pos_wide > count_wide) begin
                                res_status_next = bhpq_pkg::ST_BAD_POS;
                            end else begin
                                hole_next      = IDX_W'(pos_wide - CMP_W'(1));
                                orig_next      = IDX_W'(pos_wide - CMP_W'(1));
                                is_insert_next = 1'b0;
                                state_next     = S_UP_RD;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // Root and last entry arrive; the last entry becomes the moving key.
            S_EXT_RD: begin
                res_value_next = rd_a_reg;
                key_next       = rd_b_reg;
                hole_next      = '0;
                state_next     = S_DN_RD;
            end

            // Climb: read the parent unless the hole sits at the root.
            S_UP_RD: begin
                if (hole_reg == '0) begin
                    if (is_insert_reg) begin
                        wr_en      = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        // A modify that climbed parks its key and sinks what now
                        // sits at its start position.
                        if (hole_reg != orig_reg) begin
                            wr_en     = 1'b1;
                            hole_next = orig_reg;
                            key_next  = first_reg;
                        end
                        state_next = S_DN_RD;
                    end
                end else begin
                    state_next = S_UP_CMP;
                end
            end

            // Climb: pull the parent down or settle the key.
            S_UP_CMP: begin
                if (bhpq_pkg::ranks_above(key_reg, rd_a_reg, order_reg)) begin
                    wr_en      = 1'b1;
                    wr_data    = rd_a_reg;
                    hole_next  = parent_idx;
                    state_next = S_UP_RD;
                    if (hole_reg == orig_reg) begin
                        first_next = rd_a_reg;
                    end
                end else if (is_insert_reg) begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end else begin
                    if (hole_reg != orig_reg) begin
                        wr_en     = 1'b1;
                        hole_next = orig_reg;
                        key_next  = first_reg;
                    end
                    state_next = S_DN_RD;
                end
            end

            // Descend: read both children unless the hole is a leaf.
            S_DN_RD: begin
                rd_a_addr     = IDX_W'(left_idx);
                right_ok_next = (right_idx < count_ext);
                if (left_idx < count_ext) begin
                    state_next = S_DN_CMP;
                end else begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
            end

            // Descend: move the winning child up or settle the key.
            S_DN_CMP: begin
                if (take_right) begin
                    wr_en      = 1'b1;
                    wr_data    = rd_b_reg;
                    hole_next  = IDX_W'(right_idx);
                    state_next = S_DN_RD;
                end else if (take_left) begin
                    wr_en      = 1'b1;
                    wr_data    = rd_a_reg;
                    hole_next  = IDX_W'(left_idx);
                    state_next = S_DN_RD;
                end else begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
            end

            // Hand the response to the output register once it is free.
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register loads a response beat or drains on acceptance.
    always_comb begin
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            m_valid_next                = 1'b1;
            m_payload_next.result_value = res_value_reg;
            m_payload_next.status       = res_status_reg;
            m_payload_next.entry_count  = count_wide[6:0];
        end
    end

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers without reset.
    always_ff @(posedge aclk) begin
        hole_reg       <= hole_next;
        key_reg        <= key_next;
        is_insert_reg  <= is_insert_next;
        right_ok_reg   <= right_ok_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        orig_reg       <= orig_next;
        first_reg      <= first_next;
        m_payload_reg  <= m_payload_next;
    end

`ifndef SYNTHESIS
    // The count never exceeds the heap depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(HEAP_DEPTH))
        else $error("entry count above heap depth");

    // The count moves only when a request beat is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_valid && s_ready) |=> $stable(count_reg))
        else $error("entry count changed without a request");

    // A full response is only given when the heap really is full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && res_status_reg == bhpq_pkg::ST_FULL)
            |-> count_reg == CNT_W'(HEAP_DEPTH))
        else $error("full status with free entries");

    // The descending hole stays inside the heap, except when extract empties it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DN_RD |-> (CNT_W'(hole_reg) < count_reg || count_reg == '0))
        else $error("sift-down hole beyond entry count");

    // Only a successful extract returns a nonzero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_payload_reg.status != bhpq_pkg::ST_OK)
            |-> m_payload_reg.result_value == '0)
        else $error("error response carries a value");
`endif

endmodule
